// ===== design/snlc_pkg.sv =====
package snlc_pkg;

  // node geometry
  localparam int MAX_NODE_LENGTH = 1024;
  localparam int POS_W           = $clog2(MAX_NODE_LENGTH);
  localparam int MAG_W           = 7;
  localparam int METRIC_W        = 32;
  localparam int NUM_SLOTS       = 4;
  localparam int NUM_CANDS       = 8;
  localparam int CAND_W          = $clog2(NUM_CANDS);
  localparam int SUM_W           = MAG_W + $clog2(NUM_SLOTS);

  localparam logic [MAG_W-1:0]  MAG_MAX   = 7'd127;
  localparam logic [7:0]        LLR_MIN   = 8'h80;
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(MAX_NODE_LENGTH - 1);
  localparam logic [CAND_W-1:0] CAND_LAST = CAND_W'(NUM_CANDS - 1);

  // one weak slot
  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] pos;
  } slot_t;

  // finished node handed to the candidate generator
  typedef struct packed {
    logic                       parity;
    logic [METRIC_W-1:0]        metric;
    slot_t [NUM_SLOTS-1:0]      slots;
  } snap_t;

  // flip masks for even parity, in candidate order
  function automatic logic [NUM_SLOTS-1:0] even_mask(input logic [CAND_W-1:0] idx);
    logic [NUM_SLOTS-1:0] m;
    case (idx)
      3'd0:    m = 4'h0;
      3'd1:    m = 4'h3;
      3'd2:    m = 4'h5;
      3'd3:    m = 4'h9;
      3'd4:    m = 4'h6;
      3'd5:    m = 4'hA;
      3'd6:    m = 4'hC;
      3'd7:    m = 4'hF;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/snlc_cell.sv =====
// One slot of the sorted weak list. Takes the new word if it is smaller than
// the held entry, or takes the upstream entry when the insert lands ahead.
module snlc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        clr,
  input  logic [snlc_pkg::MAG_W-1:0]  new_mag,
  input  logic [snlc_pkg::POS_W-1:0]  new_pos,
  input  logic                        prev_lt,
  input  snlc_pkg::slot_t             prev,
  output logic                        lt,
  output snlc_pkg::slot_t             held,
  output snlc_pkg::slot_t             nxt
);

  snlc_pkg::slot_t cur;
  snlc_pkg::slot_t cur_next;

  // strict compare keeps the earlier position ahead on a tie
  assign lt = !cur.valid || (new_mag < cur.mag);

  // held entry moves down to the next slot when the insert lands ahead
  assign held = cur;

  always_comb begin
    if (prev_lt) begin
      nxt = prev;
    end else if (lt) begin
      nxt = '{valid: 1'b1, mag: new_mag, pos: new_pos};
    end else begin
      nxt = cur;
    end
  end

  // node end returns the slot to empty
  always_comb begin
    cur_next = cur;
    if (en) begin
      if (clr) begin
        cur_next = '{valid: 1'b0, mag: snlc_pkg::MAG_MAX, pos: '0};
      end else begin
        cur_next = nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '{valid: 1'b0, mag: snlc_pkg::MAG_MAX, pos: '0};
    end else begin
      cur <= cur_next;
    end
  end

endmodule

// ===== design/snlc_emit.sv =====
// Holds one finished node and walks its eight candidates out, one per word.
module snlc_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  snlc_pkg::snap_t                snap_in,
  output logic                           load_ok,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [snlc_pkg::CAND_W-1:0]    candidate,
  output logic [snlc_pkg::METRIC_W-1:0]  candidate_metric,
  output logic [snlc_pkg::NUM_SLOTS-1:0] flip_mask,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_a,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_b,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_c,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_d,
  output logic                           parity_odd,
  output logic                           last_candidate
);

  snlc_pkg::snap_t              snap;
  logic                         busy;
  logic [snlc_pkg::CAND_W-1:0]  cnt;
  logic                         out_take;
  logic [snlc_pkg::SUM_W-1:0]   flip_sum;
  logic [snlc_pkg::METRIC_W:0]  diff;

  assign out_take = busy && !out_stall;
  assign load_ok  = !busy || (out_take && (cnt == snlc_pkg::CAND_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_take) begin
      if (cnt == snlc_pkg::CAND_LAST) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= snap_in;
    end
  end

  // mask and flipped magnitude sum
  always_comb begin
    flip_mask = snlc_pkg::even_mask(cnt) ^ {{(snlc_pkg::NUM_SLOTS-1){1'b0}}, snap.parity};
    flip_sum  = '0;
    for (int b = 0; b < snlc_pkg::NUM_SLOTS; b++) begin
      if (flip_mask[b]) begin
        flip_sum = flip_sum + snlc_pkg::SUM_W'(snap.slots[b].mag);
      end
    end
  end

  // metric minus flips, saturated at the low bound
  assign diff = {snap.metric[snlc_pkg::METRIC_W-1], snap.metric}
              - {{(snlc_pkg::METRIC_W+1-snlc_pkg::SUM_W){1'b0}}, flip_sum};

  always_comb begin
    if (diff[snlc_pkg::METRIC_W] != diff[snlc_pkg::METRIC_W-1]) begin
      candidate_metric = {1'b1, {(snlc_pkg::METRIC_W-1){1'b0}}};
    end else begin
      candidate_metric = diff[snlc_pkg::METRIC_W-1:0];
    end
  end

  assign out_valid      = busy;
  assign candidate      = cnt;
  assign weak_pos_a     = snap.slots[0].pos;
  assign weak_pos_b     = snap.slots[1].pos;
  assign weak_pos_c     = snap.slots[2].pos;
  assign weak_pos_d     = snap.slots[3].pos;
  assign parity_odd     = snap.parity;
  assign last_candidate = (cnt == snlc_pkg::CAND_LAST);

endmodule

// ===== design/spc_node_list_candidates_unit.sv =====
// Channel  Handshake              Words
// in       in_valid / in_stall    llr, path_metric, last_llr
// out      out_valid / out_stall  candidate, candidate_metric, flip_mask,
//                                 weak_pos_a..d, parity_odd, last_candidate
//
// One LLR word accepted per cycle unless stalled, updating the four-cell sorted chain.
// A last LLR hands the node to the candidate generator, which sends eight words,
// one per cycle unless stalled, from the cycle after, while the next node streams in.
// A last LLR is stalled only while the previous node still has candidates to send
// (beyond the one leaving this cycle); so nodes of eight or more LLRs run at full rate.
// Synchronous reset empties the slots, parity, position count and output stage.
module spc_node_list_candidates_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [7:0]              llr,
  input  logic signed [snlc_pkg::METRIC_W-1:0] path_metric,
  input  logic                           last_llr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [snlc_pkg::CAND_W-1:0]    candidate,
  output logic signed [snlc_pkg::METRIC_W-1:0] candidate_metric,
  output logic [snlc_pkg::NUM_SLOTS-1:0] flip_mask,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_a,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_b,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_c,
  output logic [snlc_pkg::POS_W-1:0]     weak_pos_d,
  output logic                           parity_odd,
  output logic                           last_candidate
);

  logic                            in_take;
  logic                            load_ok;
  logic                            node_end;
  logic [snlc_pkg::MAG_W-1:0]      mag;
  logic [7:0]                      neg_llr;
  logic                            parity;
  logic [snlc_pkg::POS_W-1:0]      pos_count;
  logic [snlc_pkg::METRIC_W-1:0]   held_metric;
  logic [snlc_pkg::NUM_SLOTS:0]    lt_chain;
  snlc_pkg::slot_t [snlc_pkg::NUM_SLOTS:0] slot_chain;
  snlc_pkg::slot_t [snlc_pkg::NUM_SLOTS-1:0] slot_new;
  snlc_pkg::snap_t                 snap;
  logic [snlc_pkg::CAND_W-1:0]     cand_w;
  logic [snlc_pkg::METRIC_W-1:0]   metric_w;

  assign in_stall = last_llr && !load_ok;
  assign in_take  = in_valid && !in_stall;
  assign node_end = in_take && last_llr;

  // clamp to -127 and take magnitude
  assign neg_llr = -llr;
  always_comb begin
    if (!llr[7]) begin
      mag = llr[snlc_pkg::MAG_W-1:0];
    end else if (llr == snlc_pkg::LLR_MIN) begin
      mag = snlc_pkg::MAG_MAX;
    end else begin
      mag = neg_llr[snlc_pkg::MAG_W-1:0];
    end
  end

  // parity, position count and latched metric
  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      pos_count <= '0;
    end else if (in_take) begin
      if (last_llr) begin
        parity    <= 1'b0;
        pos_count <= '0;
      end else begin
        parity <= parity ^ llr[7];
        if (pos_count != snlc_pkg::POS_LAST) begin
          pos_count <= pos_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_metric <= '0;
    end else if (in_take && (pos_count == '0)) begin
      held_metric <= path_metric;
    end
  end

  // sorted chain of weak slots, smallest first; each cell hands its held entry down
  assign lt_chain[0]   = 1'b0;
  assign slot_chain[0] = '0;

  for (genvar k = 0; k < snlc_pkg::NUM_SLOTS; k++) begin : g_cell
    snlc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (in_take),
      .clr     (last_llr),
      .new_mag (mag),
      .new_pos (pos_count),
      .prev_lt (lt_chain[k]),
      .prev    (slot_chain[k]),
      .lt      (lt_chain[k+1]),
      .held    (slot_chain[k+1]),
      .nxt     (slot_new[k])
    );
    assign snap.slots[k] = slot_new[k];
  end

  // snapshot includes the final LLR
  assign snap.parity = parity ^ llr[7];
  assign snap.metric = (pos_count == '0) ? path_metric : held_metric;

  snlc_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .load             (node_end),
    .snap_in          (snap),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .candidate        (cand_w),
    .candidate_metric (metric_w),
    .flip_mask        (flip_mask),
    .weak_pos_a       (weak_pos_a),
    .weak_pos_b       (weak_pos_b),
    .weak_pos_c       (weak_pos_c),
    .weak_pos_d       (weak_pos_d),
    .parity_odd       (parity_odd),
    .last_candidate   (last_candidate)
  );

  assign candidate        = cand_w;
  assign candidate_metric = metric_w;

endmodule

// ===== design/snlc_checker.sv =====
// Port-level checks for the candidate unit.
module snlc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           last_llr,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [snlc_pkg::CAND_W-1:0]    candidate,
  input logic [snlc_pkg::NUM_SLOTS-1:0] flip_mask,
  input logic                           parity_odd,
  input logic                           last_candidate
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(candidate) && $stable(flip_mask))
    else $error("output word changed under stall");

  // a run does not break before candidate seven
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_candidate |=>
      out_valid && (candidate == snlc_pkg::CAND_W'($past(candidate) + 1'b1)))
    else $error("candidate run broken");

  // first candidate flips only the weakest slot, and only on odd parity
  a_first_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (candidate == '0) |->
      flip_mask == {{(snlc_pkg::NUM_SLOTS-1){1'b0}}, parity_odd})
    else $error("wrong mask on first candidate");

  // an input stall only happens while a run is in progress
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && last_llr)
    else $error("input stalled without a pending run");

  // a run starts at candidate zero
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> candidate == '0)
    else $error("run did not start at candidate zero");

endmodule

bind spc_node_list_candidates_unit snlc_checker u_snlc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .last_llr       (last_llr),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .candidate      (candidate),
  .flip_mask      (flip_mask),
  .parity_odd     (parity_odd),
  .last_candidate (last_candidate)
);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one candidate word as it leaves the block
  typedef struct packed {
    logic [snlc_pkg::CAND_W-1:0]          cand;
    logic signed [snlc_pkg::METRIC_W-1:0] metric;
    logic [snlc_pkg::NUM_SLOTS-1:0]       mask;
    logic [snlc_pkg::POS_W-1:0]           pos_a;
    logic [snlc_pkg::POS_W-1:0]           pos_b;
    logic [snlc_pkg::POS_W-1:0]           pos_c;
    logic [snlc_pkg::POS_W-1:0]           pos_d;
    logic                                 parity;
    logic                                 last;
  } cand_word_t;

  // flip patterns over the weak slots for an even-parity node
  localparam logic [snlc_pkg::NUM_SLOTS-1:0] EVEN_FLIPS [snlc_pkg::NUM_CANDS] =
    '{4'h0, 4'h3, 4'h5, 4'h9, 4'h6, 4'hA, 4'hC, 4'hF};
  localparam longint METRIC_FLOOR = -64'sd2147483648;

  // idle and stall rates per phase, in percent
  localparam int SEND_IDLE [4] = '{0, 76, 0, 36};
  localparam int RECV_STALL [4] = '{0, 0, 76, 36};
  localparam int PHASE_ITEMS = 70;

  // Tracks the parity and weakest LLRs of the node in flight and queues the
  // eight candidate words each finished node should produce.
  class spc_candidate_board;
    bit                                   odd;
    logic [snlc_pkg::MAG_W-1:0]           mags [snlc_pkg::NUM_SLOTS];
    logic [snlc_pkg::POS_W-1:0]           poss [snlc_pkg::NUM_SLOTS];
    int unsigned                          count;
    logic signed [snlc_pkg::METRIC_W-1:0] node_metric;
    cand_word_t                           cand_q [$];
    int                                   fails;

    function new();
      clear_node();
      node_metric = '0;
      fails = 0;
    endfunction

    function void clear_node();
      odd = 1'b0;
      foreach (mags[k]) begin
        mags[k] = snlc_pkg::MAG_MAX;
        poss[k] = '0;
      end
      count = 0;
    endfunction

    function int pending();
      return cand_q.size();
    endfunction

    // accepted LLR word: update the node, emit candidates on the last one
    function void note_llr(logic signed [7:0] l,
                           logic signed [snlc_pkg::METRIC_W-1:0] pm, logic fin);
      logic [snlc_pkg::MAG_W-1:0]     mag;
      logic [snlc_pkg::NUM_SLOTS-1:0] fm;
      int                             filled;
      int                             at;
      longint                         m;
      cand_word_t                     w;
      if (count == 0) node_metric = pm;
      odd ^= l[7];
      mag = (l == -8'sd128) ? snlc_pkg::MAG_MAX : snlc_pkg::MAG_W'(l < 0 ? -l : l);
      // sorted insert; ties leave the earlier position ahead
      filled = (count < snlc_pkg::NUM_SLOTS) ? count : snlc_pkg::NUM_SLOTS;
      at = snlc_pkg::NUM_SLOTS;
      for (int k = snlc_pkg::NUM_SLOTS - 1; k >= 0; k--)
        if (k >= filled || mag < mags[k]) at = k;
      if (at < snlc_pkg::NUM_SLOTS) begin
        for (int j = snlc_pkg::NUM_SLOTS - 1; j > at; j--) begin
          mags[j] = mags[j-1];
          poss[j] = poss[j-1];
        end
        mags[at] = mag;
        poss[at] = snlc_pkg::POS_W'(count);
      end
      if (count < snlc_pkg::MAX_NODE_LENGTH - 1) count++;
      if (!fin) return;
      for (int c = 0; c < snlc_pkg::NUM_CANDS; c++) begin
        fm = EVEN_FLIPS[c] ^ snlc_pkg::NUM_SLOTS'(odd);
        m = node_metric;
        for (int b = 0; b < snlc_pkg::NUM_SLOTS; b++)
          if (fm[b]) m -= longint'(mags[b]);
        if (m < METRIC_FLOOR) m = METRIC_FLOOR;
        w.cand   = snlc_pkg::CAND_W'(c);
        w.metric = snlc_pkg::METRIC_W'(m);
        w.mask   = fm;
        w.pos_a  = poss[0];
        w.pos_b  = poss[1];
        w.pos_c  = poss[2];
        w.pos_d  = poss[3];
        w.parity = odd;
        w.last   = (c == snlc_pkg::NUM_CANDS - 1);
        cand_q.push_back(w);
      end
      clear_node();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // accepted candidate word against the oldest expectation
    task check_word(cand_word_t got);
      cand_word_t want;
      if (cand_q.size() == 0) begin
        report($sformatf("unexpected word cand %0d metric %h", got.cand, got.metric));
        return;
      end
      want = cand_q.pop_front();
      cmp_field("candidate", 32'(got.cand), 32'(want.cand));
      cmp_field("candidate_metric", got.metric, want.metric);
      cmp_field("flip_mask", 32'(got.mask), 32'(want.mask));
      cmp_field("weak_pos_a", 32'(got.pos_a), 32'(want.pos_a));
      cmp_field("weak_pos_b", 32'(got.pos_b), 32'(want.pos_b));
      cmp_field("weak_pos_c", 32'(got.pos_c), 32'(want.pos_c));
      cmp_field("weak_pos_d", 32'(got.pos_d), 32'(want.pos_d));
      cmp_field("parity_odd", 32'(got.parity), 32'(want.parity));
      cmp_field("last_candidate", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [7:0]                    llr = '0;
  logic signed [snlc_pkg::METRIC_W-1:0] path_metric = '0;
  logic                                 last_llr = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [snlc_pkg::CAND_W-1:0]          candidate;
  logic signed [snlc_pkg::METRIC_W-1:0] candidate_metric;
  logic [snlc_pkg::NUM_SLOTS-1:0]       flip_mask;
  logic [snlc_pkg::POS_W-1:0]           weak_pos_a;
  logic [snlc_pkg::POS_W-1:0]           weak_pos_b;
  logic [snlc_pkg::POS_W-1:0]           weak_pos_c;
  logic [snlc_pkg::POS_W-1:0]           weak_pos_d;
  logic                                 parity_odd;
  logic                                 last_candidate;

  int                                   in_idle_pct = 0;
  int                                   stall_pct = 0;
  cand_word_t                           seen_word;
  spc_candidate_board                   board = new();

  spc_node_list_candidates_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .llr              (llr),
    .path_metric      (path_metric),
    .last_llr         (last_llr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .candidate        (candidate),
    .candidate_metric (candidate_metric),
    .flip_mask        (flip_mask),
    .weak_pos_a       (weak_pos_a),
    .weak_pos_b       (weak_pos_b),
    .weak_pos_c       (weak_pos_c),
    .weak_pos_d       (weak_pos_d),
    .parity_odd       (parity_odd),
    .last_candidate   (last_candidate)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // candidate side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = '{candidate, candidate_metric, flip_mask, weak_pos_a, weak_pos_b,
                    weak_pos_c, weak_pos_d, parity_odd, last_candidate};
      board.check_word(seen_word);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one LLR word, with a random idle gap ahead of it
  task automatic send_word(input logic [7:0] l,
                           input logic [snlc_pkg::METRIC_W-1:0] pm,
                           input logic fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    llr         <= l;
    path_metric <= pm;
    last_llr    <= fin;
    do @(posedge clk); while (in_stall);
    board.note_llr(l, pm, fin);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    last_llr <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // small magnitudes often, so ties and near-ties are common
  function automatic logic [7:0] random_llr();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0:       return 8'h80;
        1:       return 8'h81;
        2:       return 8'h7F;
        default: return 8'h00;
      endcase
    end
    if (r < 50) return 8'($urandom_range(16)) - 8'd8;
    return 8'($urandom);
  endfunction

  task automatic send_random_node(input int len);
    for (int i = 0; i < len; i++)
      send_word(random_llr(), $urandom, i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one-LLR node, clamp of -128, metric saturation
    send_word(8'h80, 32'h8000_0000, 1'b1);
    // two-LLR node at the top metric
    send_word(8'h7F, 32'h7FFF_FFFF, 1'b0);
    send_word(8'h00, 32'h0000_0000, 1'b1);
    // three-LLR node just above the metric floor
    send_word(8'hFF, 32'h8000_0064, 1'b0);
    send_word(8'h05, 32'h1234_5678, 1'b0);
    send_word(8'h81, 32'hFFFF_FFFF, 1'b1);
    // equal magnitudes, earlier position stays ahead
    send_word(8'd10, 32'h0000_1000, 1'b0);
    send_word(-8'sd10, 32'h5555_5555, 1'b0);
    send_word(8'd10, 32'hAAAA_AAAA, 1'b0);
    send_word(8'd20, 32'h0F0F_0F0F, 1'b0);
    send_word(-8'sd10, 32'hF0F0_F0F0, 1'b0);
    send_word(8'd3, 32'h0000_0001, 1'b1);
    // all-zero node
    for (int i = 0; i < 5; i++) send_word(8'h00, 32'h0, i == 4);
    // descending magnitudes push every slot
    send_word(8'd100, 32'hFFFF_FF00, 1'b0);
    send_word(8'd80, 32'h0, 1'b0);
    send_word(-8'sd60, 32'h0, 1'b0);
    send_word(8'd40, 32'h0, 1'b0);
    send_word(-8'sd20, 32'h0, 1'b0);
    send_word(8'd1, 32'h0, 1'b1);
    release_input();
    wait_drain();

    // random nodes under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = SEND_IDLE[ph];
      stall_pct   = RECV_STALL[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(19))
          0:       len = $urandom_range(80, 31);
          1, 2:    len = $urandom_range(30, 11);
          default: len = $urandom_range(10, 1);
        endcase
        send_random_node(len);
        sent += len;
        // now and then the sender holds off until the block has flushed everything
        if ($urandom_range(9) == 0) begin
          release_input();
          wait_drain();
        end
      end
      release_input();
      if (ph < 3) wait_drain();
    end

    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d candidate words never arrived", board.pending()));
    if (board.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== spc_node_list_candidates_unit.f =====
design/snlc_pkg.sv
design/snlc_cell.sv
design/snlc_emit.sv
design/spc_node_list_candidates_unit.sv
design/snlc_checker.sv
bench/testbench.sv
